[design/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal text block.
package sitda_pkg;

    localparam int CHAR_W = 8;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_ZERO  = 8'd48;  // '0'
    localparam t_char CH_MINUS = 8'd45;  // '-'

    // Magnitude bits folded into the BCD register per converter cycle.
    localparam int BITS_PER_STEP = 4;

    // Depth of the front queue. Must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Converter to emitter handoff control.
    typedef struct packed {
        logic valid;
        logic neg;
    } t_hand;

endpackage

[design/sitda_front.sv]
// Front end: takes words, forms sign and unsigned magnitude, queues them.
module sitda_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   i_value,
    output logic                 o_q_valid,
    input  logic                 i_q_take,
    output logic                 o_q_neg,
    output logic [WORD_BITS-1:0] o_q_mag
);
    import sitda_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic signed [63:0]   w_ext;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_neg;
    logic [WORD_BITS-1:0] w_mag;
    logic                 w_wr;
    logic                 w_rd;

    logic                 r_neg [QUEUE_DEPTH];
    logic [WORD_BITS-1:0] r_mag [QUEUE_DEPTH];
    logic [PW-1:0]        r_wp, n_wp;
    logic [PW-1:0]        r_rp, n_rp;
    logic [CW-1:0]        r_cnt, n_cnt;

    // Sign-extend then keep the low WORD_BITS bits.
    assign w_ext  = 64'(i_value);
    assign w_word = w_ext[WORD_BITS-1:0];
    assign w_neg  = w_word[WORD_BITS-1];
    // Two's complement negate as unsigned: most negative maps to 2^(W-1).
    assign w_mag  = w_neg ? (~w_word + 1'b1) : w_word;

    assign full      = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_neg   = r_neg[r_rp];
    assign o_q_mag   = r_mag[r_rp];

    assign w_wr = push && !full;
    assign w_rd = i_q_take && o_q_valid;

    always_comb begin
        n_wp  = w_wr ? PW'(r_wp + 1'b1) : r_wp;
        n_rp  = w_rd ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (w_rd && !w_wr) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_neg[r_wp] <= w_neg;
            r_mag[r_wp] <= w_mag;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("front queue count over depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("front queue empty but pointers differ");
`endif

endmodule

[design/sitda_conv.sv]
// Converter: binary magnitude to BCD by double dabble, several bits a cycle.
module sitda_conv #(
    parameter int WORD_BITS = 32,
    parameter int NDIG      = 10,
    parameter int IW        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_take,
    input  logic                 i_q_neg,
    input  logic [WORD_BITS-1:0] i_q_mag,
    output sitda_pkg::t_hand     o_hand,
    input  logic                 i_hand_ready,
    output logic [NDIG*4-1:0]    o_bcd,
    output logic [IW-1:0]        o_top
);
    import sitda_pkg::*;

    localparam int NSTEP = (WORD_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PW    = NSTEP * BITS_PER_STEP;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int BW    = NDIG * 4;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [SW-1:0]   r_step, n_step;
    logic [PW-1:0]   r_shf,  n_shf;
    logic [BW-1:0]   r_bcd,  n_bcd;
    logic            r_neg,  n_neg;
    logic [BW-1:0]   w_bcd;
    logic [PW-1:0]   w_shf;
    logic [IW-1:0]   w_top;

    // One converter cycle: BITS_PER_STEP add-3/shift rounds.
    always_comb begin
        logic [BW-1:0] bcd;
        logic [PW-1:0] shf;
        bcd = r_bcd;
        shf = r_shf;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd[d*4 +: 4] >= 4'd5) begin
                    bcd[d*4 +: 4] = 4'(bcd[d*4 +: 4] + 4'd3);
                end
            end
            bcd = {bcd[BW-2:0], shf[PW-1]};
            shf = {shf[PW-2:0], 1'b0};
        end
        w_bcd = bcd;
        w_shf = shf;
    end

    // Highest nonzero digit; zero reports digit 0.
    always_comb begin
        w_top = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                w_top = IW'(d);
            end
        end
    end

    assign o_q_take     = !r_busy && !r_done;
    assign o_hand.valid = r_done;
    assign o_hand.neg   = r_neg;
    assign o_bcd        = r_bcd;
    assign o_top        = w_top;

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_shf  = r_shf;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        if (r_busy) begin
            n_shf  = w_shf;
            n_bcd  = w_bcd;
            n_step = SW'(r_step + 1'b1);
            if (r_step == SW'(NSTEP - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (r_done) begin
            if (i_hand_ready) begin
                n_done = 1'b0;
            end
        end else if (i_q_valid) begin
            n_busy = 1'b1;
            n_step = '0;
            n_shf  = PW'(i_q_mag);
            n_bcd  = '0;
            n_neg  = i_q_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shf <= n_shf;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

`ifndef SYNTHESIS
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("converter busy and done together");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == SW'(NSTEP - 1)) |=> r_done)
        else $error("converter did not finish after last step");
`endif

endmodule

[design/sitda_emit.sv]
// Emitter: puts out the minus sign if any, then the BCD digits most significant first, into the output register.
module sitda_emit #(
    parameter int NDIG = 10,
    parameter int IW   = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sitda_pkg::t_hand    i_hand,
    output logic                o_hand_ready,
    input  logic [NDIG*4-1:0]   i_bcd,
    input  logic [IW-1:0]       i_top,
    output logic                empty,
    input  logic                pop,
    output sitda_pkg::t_char    o_character,
    output logic                o_last
);
    import sitda_pkg::*;

    logic               r_busy, n_busy;
    logic               r_sign, n_sign;
    logic [IW-1:0]      r_idx,  n_idx;
    logic [NDIG*4-1:0]  r_digs, n_digs;
    logic               r_ov,   n_ov;
    t_char              r_ch,   n_ch;
    logic               r_last, n_last;
    logic               w_adv;
    logic [3:0]         w_dig;

    assign o_hand_ready = !r_busy;
    assign empty        = !r_ov;
    assign o_character  = r_ch;
    assign o_last       = r_last;

    // Output register can take a new character.
    assign w_adv = !r_ov || pop;
    assign w_dig = r_digs[r_idx*4 +: 4];

    always_comb begin
        n_busy = r_busy;
        n_sign = r_sign;
        n_idx  = r_idx;
        n_digs = r_digs;
        n_ov   = r_ov && !pop;
        n_ch   = r_ch;
        n_last = r_last;
        if (!r_busy) begin
            if (i_hand.valid) begin
                n_busy = 1'b1;
                n_sign = i_hand.neg;
                n_idx  = i_top;
                n_digs = i_bcd;
            end
        end else if (w_adv) begin
            n_ov = 1'b1;
            if (r_sign) begin
                n_ch   = CH_MINUS;
                n_last = 1'b0;
                n_sign = 1'b0;
            end else begin
                n_ch   = CH_ZERO | t_char'(w_dig);
                n_last = (r_idx == '0);
                n_idx  = IW'(r_idx - 1'b1);
                if (r_idx == '0) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_sign <= n_sign;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_digs <= n_digs;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

`ifndef SYNTHESIS
    a_sign_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sign |-> r_busy)
        else $error("sign pending with emitter idle");
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ch == CH_MINUS) |-> !r_last)
        else $error("minus sign flagged as last");
`endif

endmodule

[design/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, put out one character per pop.
// Throughput: up to one character per cycle out while pop is held; the converter
//   works on the next number while the emitter sends out the previous one.
// Reset: synchronous, active low; empties queue, converter and output register.
module signed_int_to_decimal_ascii #(
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_character,
    output logic               o_last
);
    import sitda_pkg::*;

    // Decimal digits of 2^(WORD_BITS-1): floor((W-1)*log10 2) + 1.
    localparam int NDIG = ((WORD_BITS - 1) * 30103) / 100000 + 1;
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;

    // Front queue to converter.
    logic                 w_q_valid;
    logic                 w_q_take;
    logic                 w_q_neg;
    logic [WORD_BITS-1:0] w_q_mag;

    // Converter to emitter: BCD digits plus index of the leading digit.
    t_hand                w_hand;
    logic                 w_hand_ready;
    logic [NDIG*4-1:0]    w_bcd;
    logic [IW-1:0]        w_top;
    t_char                w_ch;

    // Accept, sign split and two-entry queue.
    sitda_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_value   (i_value),
        .o_q_valid (w_q_valid),
        .i_q_take  (w_q_take),
        .o_q_neg   (w_q_neg),
        .o_q_mag   (w_q_mag)
    );

    // Binary to BCD, four magnitude bits per cycle.
    sitda_conv #(
        .WORD_BITS (WORD_BITS),
        .NDIG      (NDIG),
        .IW        (IW)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_take     (w_q_take),
        .i_q_neg      (w_q_neg),
        .i_q_mag      (w_q_mag),
        .o_hand       (w_hand),
        .i_hand_ready (w_hand_ready),
        .o_bcd        (w_bcd),
        .o_top        (w_top)
    );

    // Sign then digits, most significant first, into the output register.
    sitda_emit #(
        .NDIG (NDIG),
        .IW   (IW)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hand       (w_hand),
        .o_hand_ready (w_hand_ready),
        .i_bcd        (w_bcd),
        .i_top        (w_top),
        .empty        (empty),
        .pop          (pop),
        .o_character  (w_ch),
        .o_last       (o_last)
    );

    assign o_character = w_ch;

endmodule

[tb/sv/sitda_text_checker.sv]
`timescale 1ns / 100ps
// Checker: predicts the decimal text of each accepted word and compares it per character.
module sitda_text_checker #(
    parameter int WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [31:0]      i_value,
    input  logic             i_empty,
    input  logic             i_pop,
    input  sitda_pkg::t_char i_character,
    input  logic             i_last,
    output int               o_fail_count,
    output int               o_pending
);
    import sitda_pkg::*;

    typedef struct {
        t_char ch;
        logic  last;
    } t_text_char;

    t_text_char text_q[$];
    int         fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Sign first, then digits most significant first; flag on the final one.
    function automatic void predict_text(input logic [31:0] value);
        logic [63:0] mask;
        logic [63:0] word;
        logic [63:0] mag;
        logic        neg;
        t_char       digits[$];
        t_text_char  tc;
        mask = {64{1'b1}} >> (64 - WORD_BITS);
        word = {32'd0, value} & mask;
        neg  = word[WORD_BITS-1];
        // unsigned magnitude, so the most negative word needs no special path
        mag  = neg ? ((~word + 64'd1) & mask) : word;
        do begin
            digits.push_front(CH_ZERO + t_char'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg) begin
            tc.ch   = CH_MINUS;
            tc.last = 1'b0;
            text_q.push_back(tc);
        end
        foreach (digits[i]) begin
            tc.ch   = digits[i];
            tc.last = (i == digits.size() - 1);
            text_q.push_back(tc);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_push && !i_full) begin
                predict_text(i_value);
            end
            if (i_pop && !i_empty) begin
                if (text_q.size() == 0) begin
                    $error("character 0x%02h last %0b popped with nothing expected",
                           i_character, i_last);
                    fails++;
                end else begin
                    want = text_q.pop_front();
                    if (i_character !== want.ch) begin
                        $error("character: expected 0x%02h, got 0x%02h", want.ch, i_character);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= text_q.size();
    end

endmodule

[tb/sv/signed_int_to_decimal_ascii_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives words into the block, pops characters, and gives the verdict.
module signed_int_to_decimal_ascii_tb;
    import sitda_pkg::*;

    localparam int WORD_BITS   = 32;
    // Worst case is ~375 words x 11 characters with random stalls plus the long hold;
    // this is several times that.
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;    // well past the first-character latency
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off to back the block up

    // Edge words: zero, unit steps, powers of ten and their neighbors,
    // both extremes, alternating bit patterns.
    localparam int EDGE_WORDS[24] = '{
        0, 1, -1, 7, -7, 9, 10, -9, -10, 99, 100, -100,
        999999999, 1000000000, -1000000000, 1999999999, 2000000000,
        2147483647, -2147483647, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 123456789, -123456789
    };

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    logic signed [31:0] i_value = '0;
    logic               empty;
    logic               pop     = 1'b0;
    logic [7:0]         o_character;
    logic               o_last;

    int fail_count;
    int pending;        // characters still owed by the block
    int cycle_count = 0;

    // Idle knobs shared with the two drivers; a max of 0 gives a gapless stretch.
    int tx_gap_max    = 11;
    int rx_gap_max    = 11;
    int rx_hold_cycles = 0;

    signed_int_to_decimal_ascii #(
        .WORD_BITS(WORD_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_character(o_character),
        .o_last     (o_last)
    );

    sitda_text_checker #(
        .WORD_BITS(WORD_BITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_value     (i_value),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_character (o_character),
        .i_last      (o_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii_tb: FAIL");
            $finish;
        end
    end

    // Offer one word after a random gap; returns at the negedge after acceptance.
    // Called at a negedge. With no gap, push stays high straight into the next word.
    task automatic send_word(input logic [31:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Random word: half the time a chosen digit count so short and long texts both
    // show up often, plus raw 32-bit noise and power-of-ten neighbors.
    function automatic logic [31:0] draw_word();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        logic   neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            1, 2: begin
                ndig = $urandom_range(1, 10);
                lo   = 1;
                repeat (ndig - 1) lo *= 10;
                hi   = lo * 10 - 1;
                if (ndig == 1) lo = 0;
                if (hi > 64'sd2147483648) hi = 64'sd2147483648;
                mag  = lo + longint'($urandom) % (hi - lo + 1);
            end
            default: begin
                mag = 1;
                repeat ($urandom_range(0, 9)) mag *= 10;
                mag = mag + $urandom_range(0, 2) - 1;
            end
        endcase
        // +2^31 does not fit; fold it onto the positive extreme
        if (!neg && mag > 64'sd2147483647) mag = 64'sd2147483647;
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    // Character receiver: random stall before each pop, plus a one-off long hold.
    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Word sender and verdict.
    initial begin
        // synchronous reset, held low, then released at a negedge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed edge words with full idling on both sides
        foreach (EDGE_WORDS[i]) send_word(EDGE_WORDS[i]);

        // random words, both sides idling
        repeat (100) send_word(draw_word());

        // no idling on either side: back-to-back words and pops
        tx_gap_max = 0;
        rx_gap_max = 0;
        repeat (60) send_word(draw_word());

        // receiver holds off while words keep coming: queue fills, full rises
        rx_gap_max     = 11;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (30) send_word(draw_word());

        // sender pause: let the block drain completely before going on
        push <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        // mixed stretches, each side idling or not per block of words
        repeat (8) begin
            tx_gap_max = $urandom_range(0, 1) ? 11 : 0;
            rx_gap_max = $urandom_range(0, 1) ? 11 : 0;
            repeat (20) send_word(draw_word());
        end
        push <= 1'b0;

        // everything owed must arrive; then watch a while for stray characters
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("signed_int_to_decimal_ascii_tb: PASS");
        end else begin
            $display("signed_int_to_decimal_ascii_tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_conv.sv
design/sitda_emit.sv
design/signed_int_to_decimal_ascii.sv
tb/sv/sitda_text_checker.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
